// File: design/dhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_pkg - shared types and constants for the distance/heading P controller
// Widths, register indexes, reset values and the per-stage control struct.
// ----------------------------------------------------------------------------
package dhp_pkg;

  // field widths
  localparam int POS_W     = 24;
  localparam int HEAD_W    = 13;
  localparam int GAIN_W    = 16;
  localparam int SPD_LIM_W = 10;
  localparam int TMO_W     = 16;
  localparam int DRIVE_W   = 12;
  localparam int ELAPSED_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // internal datapath widths
  localparam int ERR_W  = POS_W + 1;           // distance error
  localparam int HERR_W = HEAD_W + 1;          // heading error
  localparam int SPD_W  = ERR_W + GAIN_W + 1;  // error * gain, Q8
  localparam int CORR_W = HERR_W + GAIN_W + 1; // heading error * gain, Q12

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_TICKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_LIMIT_MS = 3'd7;

  // register reset values
  localparam logic [GAIN_W-1:0]    DISTANCE_GAIN_RST = 16'd512;  // 2.0 in Q8.8
  localparam logic [GAIN_W-1:0]    HEADING_GAIN_RST  = 16'd768;  // 3.0 in Q8.8
  localparam logic [SPD_LIM_W-1:0] TOLERANCE_RST     = 10'd10;
  localparam logic [SPD_LIM_W-1:0] MAX_SPEED_RST     = 10'd127;
  localparam logic [SPD_LIM_W-1:0] MIN_SPEED_RST     = 10'd20;
  localparam logic [TMO_W-1:0]     MOVE_LIMIT_MS_RST = 16'd5000;

  // command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // heading wrap, 1/16 degree units
  localparam logic signed [HERR_W-1:0] HALF_TURN = 14'sd2880;
  localparam logic signed [HERR_W-1:0] FULL_TURN = 14'sd5760;

  // drive saturation and elapsed time ceiling
  localparam logic signed [DRIVE_W-1:0] DRIVE_LIM   = 12'sd2047;
  localparam logic [ELAPSED_W-1:0]      ELAPSED_MAX = 17'd131071;

  // default control tick
  localparam int TICK_MS_DEF = 10;

  // control flags from the error stage
  typedef struct packed {
    logic start;  // start of a new move
    logic run;    // drive computed this sample
    logic done;   // move finished
    logic tmo;    // finish caused by timeout
  } dhp_ctl_t;

endpackage : dhp_pkg
`default_nettype wire

// File: design/dhp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_front - error stage
// Forms distance and heading errors, judges finish and multiplies by gains.
// ----------------------------------------------------------------------------
module dhp_front
  import dhp_pkg::*;
(
  input  wire logic                        cmd,
  input  wire logic signed [POS_W-1:0]     left_position,
  input  wire logic signed [POS_W-1:0]     right_position,
  input  wire logic        [HEAD_W-1:0]    heading,
  input  wire logic signed [POS_W-1:0]     goal_ticks,
  input  wire logic        [HEAD_W-1:0]    start_heading,
  input  wire logic        [GAIN_W-1:0]    distance_gain,
  input  wire logic        [GAIN_W-1:0]    heading_gain,
  input  wire logic        [SPD_LIM_W-1:0] tolerance,
  input  wire logic        [TMO_W-1:0]     move_limit_ms,
  input  wire logic        [ELAPSED_W-1:0] elapsed_ms,
  input  wire logic                        finished,
  input  wire logic                        ended_by_timeout,
  output dhp_ctl_t                         ctl,
  output logic signed      [SPD_W-1:0]     spd,
  output logic signed      [CORR_W-1:0]    corr
);

  logic signed [ERR_W-1:0]  pos_sum;
  logic signed [ERR_W-1:0]  pos_avg;
  logic signed [ERR_W-1:0]  err;
  logic        [ERR_W-1:0]  abs_err;
  logic                     in_tol;
  logic                     late;
  logic signed [HERR_W-1:0] herr_raw;
  logic signed [HERR_W-1:0] herr_hi;
  logic signed [HERR_W-1:0] herr;

  // average position, floor by arithmetic shift
  assign pos_sum = $signed({left_position[POS_W-1], left_position})
                 + $signed({right_position[POS_W-1], right_position});
  assign pos_avg = pos_sum >>> 1;
  assign err     = $signed({goal_ticks[POS_W-1], goal_ticks}) - pos_avg;
  assign abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

  // finish conditions
  assign in_tol = abs_err < {{(ERR_W-SPD_LIM_W){1'b0}}, tolerance};
  assign late   = elapsed_ms > {{(ELAPSED_W-TMO_W){1'b0}}, move_limit_ms};

  // heading error, wrapped once each way
  assign herr_raw = $signed({1'b0, start_heading}) - $signed({1'b0, heading});
  assign herr_hi  = (herr_raw > HALF_TURN) ? herr_raw - FULL_TURN : herr_raw;
  assign herr     = (herr_hi < -HALF_TURN) ? herr_hi + FULL_TURN : herr_hi;

  // gain products, registered by the caller
  assign spd  = err * $signed({1'b0, distance_gain});
  assign corr = herr * $signed({1'b0, heading_gain});

  // control decision
  always_comb begin
    ctl = '0;
    if (cmd == CMD_START) begin
      ctl.start = 1'b1;
    end else if (finished) begin
      ctl.done = 1'b1;
      ctl.tmo  = ended_by_timeout;
    end else if (in_tol || late) begin
      ctl.done = 1'b1;
      ctl.tmo  = !in_tol;
    end else begin
      ctl.run = 1'b1;
    end
  end

endmodule : dhp_front
`default_nettype wire

// File: design/dhp_drive.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_drive - drive stage
// Clamps and floors the base speed, applies heading correction, saturates; zero drive unless run.
// ----------------------------------------------------------------------------
module dhp_drive
  import dhp_pkg::*;
(
  input  wire logic                        run,
  input  wire logic signed [SPD_W-1:0]     spd,
  input  wire logic signed [CORR_W-1:0]    corr,
  input  wire logic        [SPD_LIM_W-1:0] max_speed,
  input  wire logic        [SPD_LIM_W-1:0] min_speed,
  output logic signed      [DRIVE_W-1:0]   left_drive,
  output logic signed      [DRIVE_W-1:0]   right_drive
);

  // clamped speed fits in a sign bit plus 19 magnitude bits
  localparam int SPDC_W = SPD_LIM_W + 8 + 2;
  localparam int Q_W    = CORR_W + 2;
  localparam int D_W    = Q_W - 12;

  logic signed [SPD_W-1:0]  hi;
  logic signed [SPD_W-1:0]  spd_clamp;
  logic signed [SPDC_W-1:0] spd_c;
  logic signed [SPDC_W-1:0] lo;
  logic signed [SPDC_W-1:0] spd_abs;
  logic signed [SPDC_W-1:0] spd_f;
  logic signed [Q_W-1:0]    q_base;
  logic signed [Q_W-1:0]    q_corr;
  logic signed [DRIVE_W-1:0] left_sat;
  logic signed [DRIVE_W-1:0] right_sat;

  // truncate toward zero by 4096, then saturate
  function automatic logic signed [DRIVE_W-1:0] to_drive(input logic signed [Q_W-1:0] q);
    logic signed [Q_W-1:0] qa;
    logic signed [D_W-1:0] d;
    qa = q[Q_W-1] ? q + Q_W'(4095) : q;
    d  = D_W'(qa >>> 12);
    if (d > D_W'(DRIVE_LIM)) begin
      to_drive = DRIVE_LIM;
    end else if (d < -D_W'(DRIVE_LIM)) begin
      to_drive = -DRIVE_LIM;
    end else begin
      to_drive = DRIVE_W'(d);
    end
  endfunction

  // clamp to +/- max_speed in Q8
  assign hi = $signed({{(SPD_W-SPD_LIM_W-8){1'b0}}, max_speed, 8'b0});
  always_comb begin
    spd_clamp = spd;
    if (spd > hi) begin
      spd_clamp = hi;
    end
    if (spd < -hi) begin
      spd_clamp = -hi;
    end
  end
  assign spd_c = SPDC_W'(spd_clamp);

  // minimum magnitude, zero goes negative
  assign lo      = $signed({2'b0, min_speed, 8'b0});
  assign spd_abs = spd_c[SPDC_W-1] ? -spd_c : spd_c;
  assign spd_f   = (spd_abs < lo) ? ((spd_c > 0) ? lo : -lo) : spd_c;

  // Q12 sums, speed sign-extended
  assign q_base    = Q_W'($signed({spd_f, 4'b0}));
  assign q_corr    = Q_W'(corr);
  assign left_sat  = to_drive(q_base - q_corr);
  assign right_sat = to_drive(q_base + q_corr);

  assign left_drive  = run ? left_sat  : '0;
  assign right_drive = run ? right_sat : '0;

endmodule : dhp_drive
`default_nettype wire

// File: design/drive_distance_heading_p_control.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drive_distance_heading_p_control - P distance drive with heading correction
// Three register stages: input, error/gain products, result.
// ----------------------------------------------------------------------------
// Each transfer on the input channel gives exactly one result, presented on
// the result port once it has passed the input, product and result registers,
// and one item is taken every cycle while the result side keeps up.
// A stall on the result side freezes all three stages at once, so in_stall
// follows out_stall whenever a result is waiting. Move state (elapsed time,
// finished, timeout cause) is updated as an item leaves the input register,
// so the next item is judged against it. Configuration writes are taken at
// any time but must only be issued while no item is in flight.
module drive_distance_heading_p_control
  import dhp_pkg::*;
#(
  parameter int TICK_MS = TICK_MS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic        [CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [CFG_DAT_W-1:0] cfg_data,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_cmd,
  input  wire logic signed [POS_W-1:0]     in_left_position,
  input  wire logic signed [POS_W-1:0]     in_right_position,
  input  wire logic        [HEAD_W-1:0]    in_heading,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed      [DRIVE_W-1:0]   out_left_drive,
  output logic signed      [DRIVE_W-1:0]   out_right_drive,
  output logic                             out_done_res,
  output logic                             out_timed_out
);

  // configuration registers
  logic signed [POS_W-1:0]     goal_ticks_r;
  logic        [HEAD_W-1:0]    start_heading_r;
  logic        [GAIN_W-1:0]    distance_gain_r;
  logic        [GAIN_W-1:0]    heading_gain_r;
  logic        [SPD_LIM_W-1:0] tolerance_r;
  logic        [SPD_LIM_W-1:0] max_speed_r;
  logic        [SPD_LIM_W-1:0] min_speed_r;
  logic        [TMO_W-1:0]     move_limit_ms_r;

  // move state
  logic [ELAPSED_W-1:0] elapsed_ms_r;
  logic [ELAPSED_W-1:0] elapsed_ms_nxt;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic                 finished_r;
  logic                 ended_by_timeout_r;

  // pipeline
  logic                        adv;
  logic                        in_valid_r;
  logic                        in_cmd_r;
  logic signed [POS_W-1:0]     in_left_r;
  logic signed [POS_W-1:0]     in_right_r;
  logic        [HEAD_W-1:0]    in_heading_r;
  dhp_ctl_t                    front_ctl;
  logic signed [SPD_W-1:0]     front_spd;
  logic signed [CORR_W-1:0]    front_corr;
  logic                        mid_valid_r;
  dhp_ctl_t                    mid_ctl_r;
  logic signed [SPD_W-1:0]     mid_spd_r;
  logic signed [CORR_W-1:0]    mid_corr_r;
  logic signed [DRIVE_W-1:0]   drv_left;
  logic signed [DRIVE_W-1:0]   drv_right;
  logic                        out_valid_r;
  logic signed [DRIVE_W-1:0]   out_left_r;
  logic signed [DRIVE_W-1:0]   out_right_r;
  logic                        out_done_r;
  logic                        out_tmo_r;

  // whole pipe moves unless a result is held
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_ticks_r    <= '0;
      start_heading_r <= '0;
      distance_gain_r <= DISTANCE_GAIN_RST;
      heading_gain_r  <= HEADING_GAIN_RST;
      tolerance_r     <= TOLERANCE_RST;
      max_speed_r     <= MAX_SPEED_RST;
      min_speed_r     <= MIN_SPEED_RST;
      move_limit_ms_r <= MOVE_LIMIT_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_TICKS:    goal_ticks_r    <= $signed(cfg_data[POS_W-1:0]);
        REG_START_HEADING: start_heading_r <= cfg_data[HEAD_W-1:0];
        REG_DISTANCE_GAIN: distance_gain_r <= cfg_data[GAIN_W-1:0];
        REG_HEADING_GAIN:  heading_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_TOLERANCE:     tolerance_r     <= cfg_data[SPD_LIM_W-1:0];
        REG_MAX_SPEED:     max_speed_r     <= cfg_data[SPD_LIM_W-1:0];
        REG_MIN_SPEED:     min_speed_r     <= cfg_data[SPD_LIM_W-1:0];
        REG_MOVE_LIMIT_MS: move_limit_ms_r <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      in_cmd_r     <= in_cmd;
      in_left_r    <= in_left_position;
      in_right_r   <= in_right_position;
      in_heading_r <= in_heading;
    end
  end

  // error stage
  dhp_front u_front (
    .cmd              (in_cmd_r),
    .left_position    (in_left_r),
    .right_position   (in_right_r),
    .heading          (in_heading_r),
    .goal_ticks       (goal_ticks_r),
    .start_heading    (start_heading_r),
    .distance_gain    (distance_gain_r),
    .heading_gain     (heading_gain_r),
    .tolerance        (tolerance_r),
    .move_limit_ms    (move_limit_ms_r),
    .elapsed_ms       (elapsed_ms_r),
    .finished         (finished_r),
    .ended_by_timeout (ended_by_timeout_r),
    .ctl              (front_ctl),
    .spd              (front_spd),
    .corr             (front_corr)
  );

  // elapsed time, saturating
  assign elapsed_sum    = {1'b0, elapsed_ms_r} + (ELAPSED_W+1)'(TICK_MS);
  assign elapsed_ms_nxt = (elapsed_sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX
                                                              : elapsed_sum[ELAPSED_W-1:0];

  // move state update as an item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_ms_r       <= '0;
      finished_r         <= 1'b0;
      ended_by_timeout_r <= 1'b0;
    end else if (adv && in_valid_r) begin
      if (front_ctl.start) begin
        elapsed_ms_r       <= '0;
        finished_r         <= 1'b0;
        ended_by_timeout_r <= 1'b0;
      end else if (front_ctl.run) begin
        elapsed_ms_r <= elapsed_ms_nxt;
      end else if (front_ctl.done && !finished_r) begin
        finished_r         <= 1'b1;
        ended_by_timeout_r <= front_ctl.tmo;
      end
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (adv) begin
      mid_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid_r) begin
      mid_ctl_r  <= front_ctl;
      mid_spd_r  <= front_spd;
      mid_corr_r <= front_corr;
    end
  end

  // drive stage
  dhp_drive u_drive (
    .run         (mid_ctl_r.run),
    .spd         (mid_spd_r),
    .corr        (mid_corr_r),
    .max_speed   (max_speed_r),
    .min_speed   (min_speed_r),
    .left_drive  (drv_left),
    .right_drive (drv_right)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mid_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && mid_valid_r) begin
      out_left_r  <= drv_left;
      out_right_r <= drv_right;
      out_done_r  <= mid_ctl_r.done;
      out_tmo_r   <= mid_ctl_r.tmo;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_drive  = out_left_r;
  assign out_right_drive = out_right_r;
  assign out_done_res    = out_done_r;
  assign out_timed_out   = out_tmo_r;

endmodule : drive_distance_heading_p_control
`default_nettype wire

// File: design/dhp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhp_checker - port-level checks for the drive controller
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module dhp_checker
  import dhp_pkg::*;
(
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic signed [DRIVE_W-1:0]   out_left_drive,
  input wire logic signed [DRIVE_W-1:0]   out_right_drive,
  input wire logic                        out_done_res,
  input wire logic                        out_timed_out
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid && out_stall) |->
      out_valid && $stable(out_left_drive) && $stable(out_right_drive)
      && $stable(out_done_res) && $stable(out_timed_out))
    else $error("result changed while stalled");

  // stalled input transfer stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(in_valid && in_stall) |-> in_valid)
    else $error("input valid dropped while stalled");

  // input backpressure only comes from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // finished move gives zero drive
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_left_drive == '0 && out_right_drive == '0)
    else $error("nonzero drive on finished move");

  // timeout flag only with finish
  a_tmo_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timed_out |-> out_done_res)
    else $error("timeout flag without finish");

endmodule : dhp_checker

bind drive_distance_heading_p_control dhp_checker u_dhp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_left_drive  (out_left_drive),
  .out_right_drive (out_right_drive),
  .out_done_res    (out_done_res),
  .out_timed_out   (out_timed_out)
);
`default_nettype wire
